// File: sv/sdrg_pkg.sv
// ----------------------------------------------------------------------------
// sdrg_pkg
// Shared types and constants for the stream decimation and rate gate.
// ----------------------------------------------------------------------------
package sdrg_pkg;

  // table geometry
  localparam int STREAMS = 16;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 32;
  localparam int TS_W    = 64;
  localparam int DEC_W   = 16;
  localparam int PER_W   = 32;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int STEP_W  = $clog2(CNT_W);

  // input beat layout, lowest bit first
  localparam int IDX_LSB    = 0;
  localparam int TS_LSB     = IDX_LSB + IDX_W;
  localparam int EN_LSB     = TS_LSB + TS_W;
  localparam int DEC_LSB    = EN_LSB + 1;
  localparam int PER_LSB    = DEC_LSB + DEC_W;
  localparam int IN_USED_W  = PER_LSB + PER_W;
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output beat layout
  localparam int OUT_USED_W = 1 + STAT_W + 1;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_COUNT    = 3'd0,
    ACT_TIMED    = 3'd1,
    ACT_RECORD   = 3'd2,
    ACT_CONFIG   = 3'd3,
    ACT_CLEAR    = 3'd4,
    ACT_FREEZE   = 3'd5,
    ACT_UNFREEZE = 3'd6
  } act_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_BAD_STATE = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_COMMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic read;
    logic check;
    logic div_start;
    logic div_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// File: sv/sdrg_ctrl.sv
// ----------------------------------------------------------------------------
// sdrg_ctrl
// Sequencer: accept, table read, due check, modulo steps, commit.
// ----------------------------------------------------------------------------
module sdrg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sdrg_pkg::sts_t sts_i,
  output sdrg_pkg::cmd_t cmd_o
);

  sdrg_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdrg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sdrg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sdrg_pkg::ST_READ;
        end
      end
      sdrg_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = sdrg_pkg::ST_CHECK;
      end
      sdrg_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.run) begin
          cmd_o.div_start = 1'b1;
          state_d         = sdrg_pkg::ST_DIV;
        end else begin
          state_d = sdrg_pkg::ST_COMMIT;
        end
      end
      sdrg_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = sdrg_pkg::ST_COMMIT;
        end
      end
      sdrg_pkg::ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = sdrg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sdrg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/sdrg_dp.sv
// ----------------------------------------------------------------------------
// sdrg_dp
// Stream table, due check, bit-serial modulo and output register.
// ----------------------------------------------------------------------------
module sdrg_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sdrg_pkg::cmd_t                  cmd_i,
  output sdrg_pkg::sts_t                  sts_o,
  input  logic [sdrg_pkg::ACT_W-1:0]      in_action_i,
  input  logic [sdrg_pkg::IN_DATA_W-1:0]  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sdrg_pkg::OUT_DATA_W-1:0] out_data_o
);

  localparam int IDX_W = sdrg_pkg::IDX_W;
  localparam int CNT_W = sdrg_pkg::CNT_W;
  localparam int TS_W  = sdrg_pkg::TS_W;
  localparam int DEC_W = sdrg_pkg::DEC_W;
  localparam int PER_W = sdrg_pkg::PER_W;

  // stream table
  logic [CNT_W-1:0] count_mem [sdrg_pkg::STREAMS];
  logic [TS_W-1:0]  last_mem  [sdrg_pkg::STREAMS];
  logic             tv_mem    [sdrg_pkg::STREAMS];
  logic             on_mem    [sdrg_pkg::STREAMS];
  logic [DEC_W-1:0] dec_mem   [sdrg_pkg::STREAMS];
  logic [PER_W-1:0] per_mem   [sdrg_pkg::STREAMS];
  logic             frozen_q;

  // captured item
  logic [sdrg_pkg::ACT_W-1:0] act_q;
  logic [IDX_W-1:0]           idx_q;
  logic [TS_W-1:0]            ts_q;
  logic                       new_en_q;
  logic [DEC_W-1:0]           new_dec_q;
  logic [PER_W-1:0]           new_per_q;

  // entry snapshot
  logic [CNT_W-1:0] count_q;
  logic [TS_W-1:0]  last_q;
  logic             tv_q;
  logic             on_q;
  logic [DEC_W-1:0] dec_q;
  logic [PER_W-1:0] per_q;

  // modulo unit
  logic [DEC_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dvd_q;
  logic [sdrg_pkg::STEP_W-1:0] step_q;
  logic              run_q;

  // output register
  logic                   out_valid_q;
  logic                   emit_q;
  sdrg_pkg::stat_e        stat_q;
  logic                   oen_q;

  logic             valid;
  logic             due;
  logic             run;
  logic [DEC_W-1:0] dec_eff;
  logic [DEC_W:0]   trial;
  logic             trial_ge;
  logic             fire;
  logic             cfg_ok;
  sdrg_pkg::stat_e  stat;
  logic             oen;
  logic [TS_W-1:0]  elapsed;

  assign valid = ({1'b0, idx_q} < (IDX_W + 1)'(sdrg_pkg::STREAMS));

  // due check on the snapshot
  assign elapsed = ts_q - last_q;
  assign due = (per_q == '0) || !tv_q || (ts_q < last_q) ||
               (elapsed >= {{(TS_W - PER_W){1'b0}}, per_q});
  assign run = valid && on_q &&
               ((act_q == sdrg_pkg::ACT_COUNT) ||
                ((act_q == sdrg_pkg::ACT_TIMED) && due));

  // one restoring remainder step
  assign dec_eff  = (dec_q == '0) ? DEC_W'(1) : dec_q;
  assign trial    = {rem_q, dvd_q[CNT_W-1]};
  assign trial_ge = (trial >= {1'b0, dec_eff});

  // result decode
  assign fire   = run_q && (rem_q == '0);
  assign cfg_ok = valid && (new_dec_q != '0) && !frozen_q;

  always_comb begin
    case (act_q) inside
      sdrg_pkg::ACT_CONFIG: begin
        if ((new_dec_q == '0) || !valid) begin
          stat = sdrg_pkg::STAT_INVALID;
        end else if (frozen_q) begin
          stat = sdrg_pkg::STAT_BAD_STATE;
        end else begin
          stat = sdrg_pkg::STAT_OK;
        end
      end
      sdrg_pkg::ACT_COUNT, sdrg_pkg::ACT_TIMED, sdrg_pkg::ACT_RECORD,
      sdrg_pkg::ACT_CLEAR, sdrg_pkg::ACT_FREEZE, sdrg_pkg::ACT_UNFREEZE: begin
        stat = sdrg_pkg::STAT_OK;
      end
      default: begin
        stat = sdrg_pkg::STAT_INVALID;
      end
    endcase
  end

  assign oen = !valid ? 1'b0 :
               ((act_q == sdrg_pkg::ACT_CONFIG) && cfg_ok) ? new_en_q : on_q;

  // item capture, entry snapshot and modulo steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q     <= in_action_i;
      idx_q     <= in_data_i[sdrg_pkg::IDX_LSB +: IDX_W];
      ts_q      <= in_data_i[sdrg_pkg::TS_LSB +: TS_W];
      new_en_q  <= in_data_i[sdrg_pkg::EN_LSB];
      new_dec_q <= in_data_i[sdrg_pkg::DEC_LSB +: DEC_W];
      new_per_q <= in_data_i[sdrg_pkg::PER_LSB +: PER_W];
    end
    if (cmd_i.read) begin
      count_q <= count_mem[idx_q];
      last_q  <= last_mem[idx_q];
      tv_q    <= tv_mem[idx_q];
      on_q    <= on_mem[idx_q];
      dec_q   <= dec_mem[idx_q];
      per_q   <= per_mem[idx_q];
    end
    if (cmd_i.check) begin
      run_q <= run;
    end
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      dvd_q  <= count_q;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? DEC_W'(trial - {1'b0, dec_eff}) : trial[DEC_W-1:0];
      dvd_q  <= {dvd_q[CNT_W-2:0], 1'b0};
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.commit) begin
      emit_q <= fire;
      stat_q <= stat;
      oen_q  <= oen;
    end
  end

  // table update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sdrg_pkg::STREAMS; i++) begin
        count_mem[i] <= '0;
        last_mem[i]  <= '0;
        tv_mem[i]    <= 1'b0;
        on_mem[i]    <= 1'b0;
        dec_mem[i]   <= DEC_W'(1);
        per_mem[i]   <= '0;
      end
      frozen_q <= 1'b0;
    end else if (cmd_i.commit) begin
      if (run_q) begin
        count_mem[idx_q] <= count_q + 1'b1;
      end
      case (act_q)
        sdrg_pkg::ACT_RECORD: begin
          if (valid) begin
            last_mem[idx_q] <= ts_q;
            tv_mem[idx_q]   <= 1'b1;
          end
        end
        sdrg_pkg::ACT_CONFIG: begin
          if (cfg_ok) begin
            on_mem[idx_q]    <= new_en_q;
            dec_mem[idx_q]   <= new_dec_q;
            per_mem[idx_q]   <= new_per_q;
            count_mem[idx_q] <= '0;
            tv_mem[idx_q]    <= 1'b0;
          end
        end
        sdrg_pkg::ACT_CLEAR: begin
          for (int i = 0; i < sdrg_pkg::STREAMS; i++) begin
            count_mem[i] <= '0;
            tv_mem[i]    <= 1'b0;
          end
        end
        sdrg_pkg::ACT_FREEZE: begin
          frozen_q <= 1'b1;
        end
        sdrg_pkg::ACT_UNFREEZE: begin
          frozen_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // output beat holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(sdrg_pkg::OUT_DATA_W - sdrg_pkg::OUT_USED_W){1'b0}},
                        oen_q, stat_q, emit_q};

  assign sts_o.run      = run;
  assign sts_o.div_last = (step_q == sdrg_pkg::STEP_W'(CNT_W - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // only the two gates may let a record through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && fire) |->
      ((act_q == sdrg_pkg::ACT_COUNT) || (act_q == sdrg_pkg::ACT_TIMED)))
    else $error("emit raised for a non-gate action");

  // freeze takes effect right after commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (act_q == sdrg_pkg::ACT_FREEZE)) |=> frozen_q)
    else $error("freeze did not set the frozen flag");

  // clear leaves the addressed stream with no count and no time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (act_q == sdrg_pkg::ACT_CLEAR)) |=>
      ((count_mem[idx_q] == '0) && !tv_mem[idx_q]))
    else $error("clear left a count or a time behind");

  // a committed result always shows on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

endmodule

// File: sv/stream_decimation_rate_gate.sv
// ----------------------------------------------------------------------------
// stream_decimation_rate_gate
// Per-stream decimation and minimum-period gate for log records.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tuser action, tdata item
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata emit/status/enabled
//
//  a gate on an enabled, due stream goes through table read, due check,
//  32 steps of the bit-serial remainder unit and commit before its result
//  shows; every other item goes through table read, due check and commit;
//  the next beat is taken only after the previous one is committed; one
//  item is in work at a time
//  reset clears the whole stream table at once: streams disabled,
//  decimation one, no counts, no times, table unfrozen
//  a result waiting on m_axis does not block a new accept; commit of the
//  following result waits until the output register is free
//
module stream_decimation_rate_gate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // action
  input  logic [sdrg_pkg::ACT_W-1:0]      s_axis_tuser_i,
  // stream_index, timestamp, new_enabled, new_decimation, new_period, pad
  input  logic [sdrg_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // emit, status, stream_enabled, pad
  output logic [sdrg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  sdrg_pkg::cmd_t cmd;
  sdrg_pkg::sts_t sts;

  // sequencer
  sdrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table and arithmetic
  sdrg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_action_i (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stream decimation and rate gate. A short table
// of directed beats walks the corner cases, then random traffic exercises
// configured streams. Every beat is run through a predictor of the stream
// table. Output beats are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STREAMS = sdrg_pkg::STREAMS;
  localparam int ACT_W   = sdrg_pkg::ACT_W;
  localparam int IDX_W   = sdrg_pkg::IDX_W;
  localparam int CNT_W   = sdrg_pkg::CNT_W;
  localparam int TS_W    = sdrg_pkg::TS_W;
  localparam int DEC_W   = sdrg_pkg::DEC_W;
  localparam int PER_W   = sdrg_pkg::PER_W;
  localparam int STAT_W  = sdrg_pkg::STAT_W;

  // action code outside the defined set
  localparam logic [ACT_W-1:0] ACT_SPARE = 3'd7;
  localparam int RANDOM_ITEMS = 1650;
  localparam int MAX_GAP      = 12;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
    logic [TS_W-1:0]  ts;
    logic             en;
    logic [DEC_W-1:0] dec;
    logic [PER_W-1:0] per;
  } gate_req_t;

  typedef struct packed {
    logic              emit;
    logic [STAT_W-1:0] status;
    logic              enabled;
  } verdict_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            s_valid = 1'b0;
  logic                            s_ready;
  logic [ACT_W-1:0]                s_user = '0;
  logic [sdrg_pkg::IN_DATA_W-1:0]  s_data = '0;
  logic                            m_valid;
  logic                            m_ready = 1'b0;
  logic [sdrg_pkg::OUT_DATA_W-1:0] m_data;

  // mirrored stream table
  logic [CNT_W-1:0] ev_count   [STREAMS];
  logic [TS_W-1:0]  last_emit  [STREAMS];
  logic             time_known [STREAMS];
  logic             stream_on  [STREAMS];
  logic [DEC_W-1:0] decim      [STREAMS];
  logic [PER_W-1:0] period     [STREAMS];
  logic             frozen;

  // per-stream notion of current time for random timestamps
  logic [TS_W-1:0] stream_now [STREAMS];

  verdict_t  verdicts_due [$];
  gate_req_t directed_reqs [$];
  verdict_t  directed_verdicts [$];
  bit        directed_typed [$];

  int  fails = 0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  stream_decimation_rate_gate u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tuser_i  (s_user),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1_500_000;
    $display("tb_top failed");
    $finish;
  end

  // decimation counter step, returns the emit decision
  function automatic logic count_gate(input logic [IDX_W-1:0] s);
    logic [DEC_W-1:0] d;
    logic             fire;
    d = (decim[s] == '0) ? DEC_W'(1) : decim[s];
    fire = ((ev_count[s] % {16'd0, d}) == '0);
    ev_count[s] = ev_count[s] + 1'b1;
    return fire;
  endfunction

  // apply one beat to the mirrored table and return the gate verdict
  function automatic verdict_t predict_verdict(input gate_req_t r);
    verdict_t v;
    logic     due;
    v.emit    = 1'b0;
    v.status  = sdrg_pkg::STAT_OK;
    v.enabled = 1'b0;
    case (r.act)
      sdrg_pkg::ACT_COUNT: begin
        if (stream_on[r.idx]) v.emit = count_gate(r.idx);
      end
      sdrg_pkg::ACT_TIMED: begin
        if (stream_on[r.idx]) begin
          due = (period[r.idx] == '0) || !time_known[r.idx] ||
                (r.ts < last_emit[r.idx]) ||
                ((r.ts - last_emit[r.idx]) >= {32'd0, period[r.idx]});
          if (due) v.emit = count_gate(r.idx);
        end
      end
      sdrg_pkg::ACT_RECORD: begin
        last_emit[r.idx]  = r.ts;
        time_known[r.idx] = 1'b1;
      end
      sdrg_pkg::ACT_CONFIG: begin
        if (r.dec == '0) begin
          v.status = sdrg_pkg::STAT_INVALID;
        end else if (frozen) begin
          v.status = sdrg_pkg::STAT_BAD_STATE;
        end else begin
          stream_on[r.idx]  = r.en;
          decim[r.idx]      = r.dec;
          period[r.idx]     = r.per;
          ev_count[r.idx]   = '0;
          time_known[r.idx] = 1'b0;
        end
      end
      sdrg_pkg::ACT_CLEAR: begin
        for (int k = 0; k < STREAMS; k++) begin
          ev_count[k]   = '0;
          time_known[k] = 1'b0;
        end
      end
      sdrg_pkg::ACT_FREEZE:   frozen = 1'b1;
      sdrg_pkg::ACT_UNFREEZE: frozen = 1'b0;
      default:                v.status = sdrg_pkg::STAT_INVALID;
    endcase
    v.enabled = stream_on[r.idx];
    return v;
  endfunction

  // random beat, biased toward a few configured streams
  function automatic gate_req_t draw_req();
    gate_req_t r;
    int        pick;
    r.idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, STREAMS - 1))
                                        : IDX_W'($urandom_range(0, 3));
    r.ts  = {$urandom, $urandom};
    r.en  = 1'($urandom_range(0, 1));
    r.dec = DEC_W'($urandom);
    r.per = $urandom;
    pick  = $urandom_range(0, 99);
    if (pick < 35) begin
      r.act = sdrg_pkg::ACT_COUNT;
    end else if (pick < 80) begin
      r.act = (pick < 70) ? sdrg_pkg::ACT_TIMED : sdrg_pkg::ACT_RECORD;
      stream_now[r.idx] = stream_now[r.idx] + $urandom_range(0, 40);
      case ($urandom_range(0, 19))
        0:       r.ts = stream_now[r.idx] - $urandom_range(1, 200);
        1:       r.ts = r.ts;
        default: r.ts = stream_now[r.idx];
      endcase
    end else if (pick < 91) begin
      r.act = sdrg_pkg::ACT_CONFIG;
      r.en  = ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 15))
        0:       r.dec = '0;
        1, 2:    r.dec = r.dec;
        default: r.dec = DEC_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0:          r.per = r.per;
        1, 2, 3:    r.per = '0;
        default:    r.per = $urandom_range(1, 60);
      endcase
    end else if (pick < 94) begin
      r.act = sdrg_pkg::ACT_CLEAR;
    end else if (pick < 95) begin
      r.act = sdrg_pkg::ACT_FREEZE;
    end else if (pick < 99) begin
      r.act = sdrg_pkg::ACT_UNFREEZE;
    end else begin
      r.act = ACT_SPARE;
    end
    return r;
  endfunction

  // directed table entry
  task automatic add_row(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                         input logic [TS_W-1:0] ts, input logic en,
                         input logic [DEC_W-1:0] dec, input logic [PER_W-1:0] per,
                         input bit typed, input logic emit,
                         input logic [STAT_W-1:0] status, input logic enabled);
    gate_req_t r;
    verdict_t  v;
    r.act = act; r.idx = idx; r.ts = ts; r.en = en; r.dec = dec; r.per = per;
    v.emit = emit; v.status = status; v.enabled = enabled;
    directed_reqs.push_back(r);
    directed_verdicts.push_back(v);
    directed_typed.push_back(typed);
  endtask

  // present one beat on s_axis and return at the edge it is taken
  task automatic send_req(input gate_req_t r);
    logic [sdrg_pkg::IN_DATA_W-1:0] beat;
    int                             gap;
    if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    beat = '0;
    beat[sdrg_pkg::IDX_LSB +: IDX_W] = r.idx;
    beat[sdrg_pkg::TS_LSB +: TS_W]   = r.ts;
    beat[sdrg_pkg::EN_LSB]           = r.en;
    beat[sdrg_pkg::DEC_LSB +: DEC_W] = r.dec;
    beat[sdrg_pkg::PER_LSB +: PER_W] = r.per;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= r.act;
    s_data  <= beat;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // stimulus
  initial begin
    gate_req_t r;
    verdict_t  v;
    for (int k = 0; k < STREAMS; k++) begin
      ev_count[k]   = '0;
      last_emit[k]  = '0;
      time_known[k] = 1'b0;
      stream_on[k]  = 1'b0;
      decim[k]      = DEC_W'(1);
      period[k]     = '0;
      stream_now[k] = TS_W'($urandom_range(0, 1000));
    end
    frozen = 1'b0;

    // after reset: everything disabled
    add_row(sdrg_pkg::ACT_COUNT, 4'd0, '0, 1'b0, 16'd1, '0,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b0);
    add_row(sdrg_pkg::ACT_TIMED, 4'd15, '1, 1'b1, '1, '1,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b0);
    // zero decimation rejected
    add_row(sdrg_pkg::ACT_CONFIG, 4'd0, '0, 1'b1, 16'd0, '1,
            1'b1, 1'b0, sdrg_pkg::STAT_INVALID, 1'b0);
    add_row(sdrg_pkg::ACT_CONFIG, 4'd0, '0, 1'b1, 16'd1, '0,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b1);
    add_row(sdrg_pkg::ACT_COUNT, 4'd0, '0, 1'b0, '0, '0,
            1'b1, 1'b1, sdrg_pkg::STAT_OK, 1'b1);
    // widest settings on the top stream
    add_row(sdrg_pkg::ACT_CONFIG, 4'd15, '1, 1'b1, '1, '1,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b1);
    add_row(sdrg_pkg::ACT_COUNT, 4'd15, '0, 1'b0, '0, '0,
            1'b1, 1'b1, sdrg_pkg::STAT_OK, 1'b1);
    add_row(sdrg_pkg::ACT_COUNT, 4'd15, '1, 1'b1, '1, '1,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b1);
    add_row(sdrg_pkg::ACT_RECORD, 4'd15, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0, '0,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b1);
    // one microsecond later, far from due
    add_row(sdrg_pkg::ACT_TIMED, 4'd15, '1, 1'b0, '0, '0,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b1);
    // time went backwards: due
    add_row(sdrg_pkg::ACT_TIMED, 4'd15, '0, 1'b0, '0, '0,
            1'b0, 1'b0, sdrg_pkg::STAT_OK, 1'b0);
    // period boundary
    add_row(sdrg_pkg::ACT_CONFIG, 4'd3, '0, 1'b1, 16'd3, 32'd100,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b1);
    add_row(sdrg_pkg::ACT_RECORD, 4'd3, 64'd1000, 1'b0, '0, '0,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b1);
    add_row(sdrg_pkg::ACT_TIMED, 4'd3, 64'd1099, 1'b0, '0, '0,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b1);
    add_row(sdrg_pkg::ACT_TIMED, 4'd3, 64'd1100, 1'b0, '0, '0,
            1'b1, 1'b1, sdrg_pkg::STAT_OK, 1'b1);
    add_row(sdrg_pkg::ACT_TIMED, 4'd3, 64'd500, 1'b0, '0, '0,
            1'b0, 1'b0, sdrg_pkg::STAT_OK, 1'b0);
    // frozen table
    add_row(sdrg_pkg::ACT_FREEZE, 4'd3, '0, 1'b0, '0, '0,
            1'b0, 1'b0, sdrg_pkg::STAT_OK, 1'b0);
    add_row(sdrg_pkg::ACT_CONFIG, 4'd3, '0, 1'b0, 16'd2, 32'd7,
            1'b1, 1'b0, sdrg_pkg::STAT_BAD_STATE, 1'b1);
    add_row(sdrg_pkg::ACT_CONFIG, 4'd3, '0, 1'b1, 16'd0, 32'd7,
            1'b1, 1'b0, sdrg_pkg::STAT_INVALID, 1'b1);
    add_row(sdrg_pkg::ACT_RECORD, 4'd3, 64'd5, 1'b0, '0, '0,
            1'b0, 1'b0, sdrg_pkg::STAT_OK, 1'b0);
    add_row(sdrg_pkg::ACT_CLEAR, 4'd3, '0, 1'b0, '0, '0,
            1'b0, 1'b0, sdrg_pkg::STAT_OK, 1'b0);
    add_row(sdrg_pkg::ACT_TIMED, 4'd3, 64'd6, 1'b0, '0, '0,
            1'b0, 1'b0, sdrg_pkg::STAT_OK, 1'b0);
    add_row(sdrg_pkg::ACT_UNFREEZE, 4'd0, '0, 1'b0, '0, '0,
            1'b0, 1'b0, sdrg_pkg::STAT_OK, 1'b0);
    // undefined action code
    add_row(ACT_SPARE, 4'd0, '1, 1'b1, '1, '1,
            1'b1, 1'b0, sdrg_pkg::STAT_INVALID, 1'b1);
    add_row(sdrg_pkg::ACT_CONFIG, 4'd0, '0, 1'b0, 16'd1, '0,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b0);
    add_row(sdrg_pkg::ACT_COUNT, 4'd0, '0, 1'b0, '0, '0,
            1'b1, 1'b0, sdrg_pkg::STAT_OK, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_reqs[i]) begin
      send_req(directed_reqs[i]);
      v = predict_verdict(directed_reqs[i]);
      verdicts_due.push_back(directed_typed[i] ? directed_verdicts[i] : v);
    end

    // random traffic
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // hold off until the block has drained
      if (n == RANDOM_ITEMS / 2) begin
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
      end
      r = draw_req();
      send_req(r);
      verdicts_due.push_back(predict_verdict(r));
    end
    s_valid <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // result side: random stalls, in-order compare
  initial begin
    verdict_t got;
    verdict_t want;
    int       stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
      got.emit    = m_data[0];
      got.status  = m_data[2:1];
      got.enabled = m_data[3];
      if (verdicts_due.size() == 0) begin
        $error("result beat with no expected result pending");
        fails++;
      end else begin
        want = verdicts_due.pop_front();
        if (got.emit !== want.emit) begin
          $error("emit: expected %0d, got %0d", want.emit, got.emit);
          fails++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fails++;
        end
        if (got.enabled !== want.enabled) begin
          $error("stream_enabled: expected %0d, got %0d", want.enabled, got.enabled);
          fails++;
        end
      end
    end
  end

endmodule
